/* rtl/spcr_pkg.sv */
// Shared widths, pipeline item type and arithmetic helpers for the sphere pair resolver.
package spcr_pkg;

    // Field widths of the channels
    localparam int CB   = 21;          // bits per packed coordinate component
    localparam int POSW = 3 * CB;      // packed position or velocity vector
    localparam int RW   = 20;          // radius
    localparam int MW   = 16;          // mass, Q8.8
    localparam int EW   = 9;           // restitution, Q1.8
    localparam int NW   = 16;          // normal component, Q1.14
    localparam int NRMW = 3 * NW;

    // Internal widths
    localparam int DW   = CB + 1;          // coordinate difference
    localparam int SQW  = 2 * CB;          // squared difference magnitude
    localparam int D2W  = 2 * CB + 2;      // squared distance
    localparam int RADW = D2W + 16;        // radicand, squared distance scaled by 2^16
    localparam int LW   = RADW / 2;        // root of the scaled radicand
    localparam int SRW  = LW + 2;          // root remainder
    localparam int DSTW = LW - 8;          // center distance
    localparam int MSW  = MW + 1;          // mass sum
    localparam int NQ   = NW - 1;          // normal magnitude
    localparam int NSH  = 22;              // normal and position scale shift
    localparam int NNUM = CB + NSH + 1;    // normal dividend
    localparam int CQ   = CB + 8;          // position scalar
    localparam int CNUM = CB + MW + 8;     // position scalar dividend
    localparam int VPW  = DW + NW;         // relative velocity times normal
    localparam int VNW  = VPW + 2;         // normal velocity sum
    localparam int WW   = CB + 25;         // impulse magnitude before mass split
    localparam int KQ   = WW;              // impulse scalar
    localparam int KNUM = WW + MW;         // impulse scalar dividend
    localparam int KSH  = 36;              // impulse scale shift
    localparam int PCW  = CQ + NQ;         // position scalar times normal
    localparam int PKW  = KQ + NQ;         // impulse scalar times normal
    localparam int EMAX = 256;             // restitution of 1.0

    // One pair as it moves down the pipeline
    typedef struct packed {
        logic [2:0][CB-1:0]  pa;
        logic [2:0][CB-1:0]  pb;
        logic [2:0][CB-1:0]  va;
        logic [2:0][CB-1:0]  vb;
        logic [2:0][DW-1:0]  d;
        logic [MW-1:0]       ma;
        logic [MW-1:0]       mb;
        logic [MSW-1:0]      msum;
        logic [EW-1:0]       e;
        logic [CB-1:0]       rsum;
        logic [2:0][SQW-1:0] sq;
        logic                zero;
        logic [RADW-1:0]     rad;
        logic [SRW-1:0]      srem;
        logic [LW-1:0]       root;
        logic                hit;
        logic [CB-1:0]       pen;
        logic [2:0][LW-1:0]  nrem;
        logic [2:0][NQ-1:0]  nlow;
        logic [MSW-1:0]      crem_a;
        logic [MSW-1:0]      crem_b;
        logic [CQ-1:0]       clow_a;
        logic [CQ-1:0]       clow_b;
        logic [2:0][NQ-1:0]  nmag;
        logic [2:0][NW-1:0]  nrm;
        logic [2:0][VPW-1:0] pv;
        logic [VNW-1:0]      vn;
        logic [WW-1:0]       w;
        logic [MSW-1:0]      krem_a;
        logic [MSW-1:0]      krem_b;
        logic [KQ-1:0]       klow_a;
        logic [KQ-1:0]       klow_b;
        logic [2:0][PCW-1:0] pca;
        logic [2:0][PCW-1:0] pcb;
        logic [2:0][PKW-1:0] pka;
        logic [2:0][PKW-1:0] pkb;
    } item_t;

    // One restoring division step by the mass sum: {quotient bit, new remainder}
    function automatic logic [MSW:0] msum_step(input logic [MSW-1:0] rem,
                                               input logic nb,
                                               input logic [MSW-1:0] dvs);
        logic [MSW:0] r2;
        r2 = {rem, nb};
        if (r2 >= {1'b0, dvs})
            return {1'b1, MSW'(r2 - {1'b0, dvs})};
        else
            return {1'b0, r2[MSW-1:0]};
    endfunction

    // One restoring division step by the scaled length: {quotient bit, new remainder}
    function automatic logic [LW:0] len_step(input logic [LW-1:0] rem,
                                             input logic nb,
                                             input logic [LW-1:0] dvs);
        logic [LW:0] r2;
        r2 = {rem, nb};
        if (r2 >= {1'b0, dvs})
            return {1'b1, LW'(r2 - {1'b0, dvs})};
        else
            return {1'b0, r2[LW-1:0]};
    endfunction

    // Clamp to the signed coordinate range
    function automatic logic [CB-1:0] sat_coord(input logic signed [31:0] v);
        logic signed [31:0] cmax;
        logic signed [31:0] cmin;
        cmax = 32'sd1 <<< (CB - 1);
        cmax = cmax - 32'sd1;
        cmin = -cmax - 32'sd1;
        if (v > cmax)
            return cmax[CB-1:0];
        else if (v < cmin)
            return cmin[CB-1:0];
        else
            return v[CB-1:0];
    endfunction

endpackage

/* rtl/spcr_in_if.sv */
// Input channel: one sphere pair per transfer.
interface spcr_in_if import spcr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [POSW-1:0] pos_a;
    logic [POSW-1:0] vel_a;
    logic [RW-1:0]   radius_a;
    logic [MW-1:0]   mass_a;
    logic [EW-1:0]   restitution_a;
    logic [POSW-1:0] pos_b;
    logic [POSW-1:0] vel_b;
    logic [RW-1:0]   radius_b;
    logic [MW-1:0]   mass_b;
    logic [EW-1:0]   restitution_b;

    modport source (output valid, pos_a, vel_a, radius_a, mass_a, restitution_a,
                    pos_b, vel_b, radius_b, mass_b, restitution_b,
                    input ready);
    modport sink   (input valid, pos_a, vel_a, radius_a, mass_a, restitution_a,
                    pos_b, vel_b, radius_b, mass_b, restitution_b,
                    output ready);
endinterface

/* rtl/spcr_out_if.sv */
// Output channel: one resolved pair per transfer.
interface spcr_out_if import spcr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            hit;
    logic [CB-1:0]   penetration;
    logic [NRMW-1:0] normal;
    logic [POSW-1:0] new_pos_a;
    logic [POSW-1:0] new_vel_a;
    logic [POSW-1:0] new_pos_b;
    logic [POSW-1:0] new_vel_b;

    modport source (output valid, hit, penetration, normal,
                    new_pos_a, new_vel_a, new_pos_b, new_vel_b,
                    input ready);
    modport sink   (input valid, hit, penetration, normal,
                    new_pos_a, new_vel_a, new_pos_b, new_vel_b,
                    output ready);
endinterface

/* rtl/sphere_pair_collision_resolve_core.sv */
// Sphere pair collision resolver: takes one pair per cycle unless the output stalls, and
// presents each result through a 102-stage pipeline. The depth is set by the
// 30-step square root of the scaled squared distance, the 15-step normal divider and the
// 46-step impulse divider, one result bit per stage. Each stage holds a valid bit and the
// ready signal chains back through empty stages, so bubbles close up and the input keeps
// taking pairs while a finished result waits at the output register and a stage is empty.
module sphere_pair_collision_resolve_core import spcr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    spcr_in_if.sink   bodies,
    spcr_out_if.source result
);

    // Stage map
    localparam int S_IN   = 0;
    localparam int S_SQ   = S_IN + 1;
    localparam int S_D2   = S_SQ + 1;
    localparam int S_SR0  = S_D2 + 1;
    localparam int S_HIT  = S_SR0 + LW;
    localparam int S_ND0  = S_HIT + 1;
    localparam int S_CPRD = S_HIT + 1;
    localparam int S_CD0  = S_CPRD + 1;
    localparam int S_NFIN = S_ND0 + NQ;
    localparam int S_VPRD = S_NFIN + 1;
    localparam int S_VN   = S_VPRD + 1;
    localparam int S_W    = S_VN + 1;
    localparam int S_KPRD = S_W + 1;
    localparam int S_KD0  = S_KPRD + 1;
    localparam int S_PPRD = S_CD0 + CQ;
    localparam int S_PAPP = S_PPRD + 1;
    localparam int S_KMUL = S_KD0 + KQ;
    localparam int S_VAPP = S_KMUL + 1;
    localparam int NS     = S_VAPP + 1;

    localparam logic [PCW:0] PHALF = (PCW+1)'(1) << (NSH - 1);
    localparam logic [PKW:0] KHALF = (PKW+1)'(1) << (KSH - 1);

    item_t          stg_reg [NS];
    logic [NS-1:0]  valid_reg;
    logic [NS-1:0]  rdy;
    item_t          src;

    // Input capture: unpack, clamp masses, take the smaller restitution and clamp it, radii sum
    always_comb
    begin
        logic [EW-1:0] ecmp;
        src = '0;
        src.pa = bodies.pos_a;
        src.pb = bodies.pos_b;
        src.va = bodies.vel_a;
        src.vb = bodies.vel_b;
        src.ma = (bodies.mass_a == '0) ? MW'(1) : bodies.mass_a;
        src.mb = (bodies.mass_b == '0) ? MW'(1) : bodies.mass_b;
        src.msum = MSW'(src.ma) + MSW'(src.mb);
        ecmp = (bodies.restitution_a < bodies.restitution_b) ? bodies.restitution_a
                                                              : bodies.restitution_b;
        src.e = (ecmp > EW'(EMAX)) ? EW'(EMAX) : ecmp;
        src.rsum = CB'(bodies.radius_a) + CB'(bodies.radius_b);
    end

    // Ready chain: a stage loads when it is empty or its successor loads
    assign rdy[NS-1] = !valid_reg[NS-1] || result.ready;
    for (genvar k = 0; k < NS - 1; k++)
    begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign bodies.ready = rdy[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        item_t stg_prev;
        item_t stg_next;

        if (k == 0)
        begin : g_first
            assign stg_prev = src;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (rdy[k])
                    valid_reg[k] <= bodies.valid;
            end
        end
        else
        begin : g_rest
            assign stg_prev = stg_reg[k-1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end

        // Work of this stage
        always_comb
        begin
            logic [CB-1:0]   magd;
            logic [D2W-1:0]  d2;
            logic [SRW+1:0]  r2s;
            logic [SRW-1:0]  trial;
            logic [DSTW-1:0] cdist;
            logic [NNUM-1:0] numn;
            logic [LW:0]     tn;
            logic [CNUM-1:0] cnum;
            logic [MSW:0]    tc;
            logic [NQ-1:0]   nm;
            logic [DW-1:0]   dv;
            logic [VNW-1:0]  vsum;
            logic [VNW-1:0]  vmag;
            logic [EW:0]     ew;
            logic [KNUM-1:0] knum;
            logic [PCW:0]    rndp;
            logic [PKW:0]    rndk;
            logic signed [31:0] corr;

            magd  = '0;
            d2    = '0;
            r2s   = '0;
            trial = '0;
            cdist = '0;
            numn  = '0;
            tn    = '0;
            cnum  = '0;
            tc    = '0;
            nm    = '0;
            dv    = '0;
            vsum  = '0;
            vmag  = '0;
            ew    = '0;
            knum  = '0;
            rndp  = '0;
            rndk  = '0;
            corr  = '0;
            stg_next = stg_prev;

            // Center difference B - A
            if (k == S_IN)
            begin
                for (int i = 0; i < 3; i++)
                    stg_next.d[i] = {stg_prev.pb[i][CB-1], stg_prev.pb[i]}
                                  - {stg_prev.pa[i][CB-1], stg_prev.pa[i]};
            end

            // Squared magnitudes
            if (k == S_SQ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    magd = stg_prev.d[i][CB] ? CB'(-stg_prev.d[i]) : stg_prev.d[i][CB-1:0];
                    stg_next.sq[i] = SQW'(magd) * SQW'(magd);
                end
            end

            // Squared distance, start of the root
            if (k == S_D2)
            begin
                d2 = D2W'(stg_prev.sq[0]) + D2W'(stg_prev.sq[1]) + D2W'(stg_prev.sq[2]);
                stg_next.zero = (d2 == '0);
                stg_next.rad  = {d2, 16'b0};
                stg_next.srem = '0;
                stg_next.root = '0;
            end

            // One root bit per stage
            if (k >= S_SR0 && k < S_SR0 + LW)
            begin
                r2s   = {stg_prev.srem, stg_prev.rad[RADW-1 -: 2]};
                trial = {stg_prev.root, 2'b01};
                if (r2s >= (SRW+2)'(trial))
                begin
                    stg_next.srem = SRW'(r2s - (SRW+2)'(trial));
                    stg_next.root = {stg_prev.root[LW-2:0], 1'b1};
                end
                else
                begin
                    stg_next.srem = r2s[SRW-1:0];
                    stg_next.root = {stg_prev.root[LW-2:0], 1'b0};
                end
                stg_next.rad = stg_prev.rad << 2;
            end

            // Overlap test, penetration, normal dividend
            if (k == S_HIT)
            begin
                cdist = DSTW'(stg_prev.root >> 8);
                stg_next.hit = (cdist < DSTW'(stg_prev.rsum));
                stg_next.pen = stg_next.hit ? stg_prev.rsum - CB'(cdist) : '0;
                for (int i = 0; i < 3; i++)
                begin
                    magd = stg_prev.d[i][CB] ? CB'(-stg_prev.d[i]) : stg_prev.d[i][CB-1:0];
                    numn = (NNUM'(magd) << NSH) + NNUM'(stg_prev.root >> 1);
                    stg_next.nrem[i] = LW'(numn >> NQ);
                    stg_next.nlow[i] = numn[NQ-1:0];
                end
            end

            // Normal division, one bit per stage
            if (k >= S_ND0 && k < S_ND0 + NQ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tn = len_step(stg_prev.nrem[i], stg_prev.nlow[i][NQ-1], stg_prev.root);
                    stg_next.nrem[i] = tn[LW-1:0];
                    stg_next.nlow[i] = {stg_prev.nlow[i][NQ-2:0], tn[LW]};
                end
            end

            // Position split dividends
            if (k == S_CPRD)
            begin
                cnum = CNUM'(stg_prev.pen) * CNUM'(stg_prev.mb);
                cnum = cnum << 8;
                stg_next.crem_a = MSW'(cnum >> CQ);
                stg_next.clow_a = cnum[CQ-1:0];
                cnum = CNUM'(stg_prev.pen) * CNUM'(stg_prev.ma);
                cnum = cnum << 8;
                stg_next.crem_b = MSW'(cnum >> CQ);
                stg_next.clow_b = cnum[CQ-1:0];
            end

            // Position split division
            if (k >= S_CD0 && k < S_CD0 + CQ)
            begin
                tc = msum_step(stg_prev.crem_a, stg_prev.clow_a[CQ-1], stg_prev.msum);
                stg_next.crem_a = tc[MSW-1:0];
                stg_next.clow_a = {stg_prev.clow_a[CQ-2:0], tc[MSW]};
                tc = msum_step(stg_prev.crem_b, stg_prev.clow_b[CQ-1], stg_prev.msum);
                stg_next.crem_b = tc[MSW-1:0];
                stg_next.clow_b = {stg_prev.clow_b[CQ-2:0], tc[MSW]};
            end

            // Signed normal, zero for a miss or coincident centers
            if (k == S_NFIN)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nm = (stg_prev.hit && !stg_prev.zero) ? stg_prev.nlow[i] : '0;
                    stg_next.nmag[i] = nm;
                    stg_next.nrm[i]  = stg_prev.d[i][CB] ? NW'(0) - NW'(nm) : NW'(nm);
                end
            end

            // Relative velocity along the normal, per component
            if (k == S_VPRD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv = {stg_prev.vb[i][CB-1], stg_prev.vb[i]}
                       - {stg_prev.va[i][CB-1], stg_prev.va[i]};
                    stg_next.pv[i] = VPW'($signed(dv)) * VPW'($signed(stg_prev.nrm[i]));
                end
            end

            if (k == S_VN)
            begin
                vsum = VNW'($signed(stg_prev.pv[0])) + VNW'($signed(stg_prev.pv[1]))
                     + VNW'($signed(stg_prev.pv[2]));
                stg_next.vn = vsum;
            end

            // Impulse magnitude, zero unless approaching
            if (k == S_W)
            begin
                vmag = VNW'(0) - stg_prev.vn;
                ew   = (EW+1)'(EMAX) + (EW+1)'(stg_prev.e);
                stg_next.w = stg_prev.vn[VNW-1] ? WW'(vmag) * WW'(ew) : '0;
            end

            // Impulse split dividends
            if (k == S_KPRD)
            begin
                knum = KNUM'(stg_prev.w) * KNUM'(stg_prev.mb);
                stg_next.krem_a = MSW'(knum >> KQ);
                stg_next.klow_a = knum[KQ-1:0];
                knum = KNUM'(stg_prev.w) * KNUM'(stg_prev.ma);
                stg_next.krem_b = MSW'(knum >> KQ);
                stg_next.klow_b = knum[KQ-1:0];
            end

            // Impulse split division
            if (k >= S_KD0 && k < S_KD0 + KQ)
            begin
                tc = msum_step(stg_prev.krem_a, stg_prev.klow_a[KQ-1], stg_prev.msum);
                stg_next.krem_a = tc[MSW-1:0];
                stg_next.klow_a = {stg_prev.klow_a[KQ-2:0], tc[MSW]};
                tc = msum_step(stg_prev.krem_b, stg_prev.klow_b[KQ-1], stg_prev.msum);
                stg_next.krem_b = tc[MSW-1:0];
                stg_next.klow_b = {stg_prev.klow_b[KQ-2:0], tc[MSW]};
            end

            // Position corrections
            if (k == S_PPRD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    stg_next.pca[i] = PCW'(stg_prev.clow_a) * PCW'(stg_prev.nmag[i]);
                    stg_next.pcb[i] = PCW'(stg_prev.clow_b) * PCW'(stg_prev.nmag[i]);
                end
            end

            if (k == S_PAPP)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rndp = {1'b0, stg_prev.pca[i]} + PHALF;
                    corr = 32'(rndp >> NSH);
                    stg_next.pa[i] = stg_prev.d[i][CB]
                        ? sat_coord(32'($signed(stg_prev.pa[i])) + corr)
                        : sat_coord(32'($signed(stg_prev.pa[i])) - corr);
                    rndp = {1'b0, stg_prev.pcb[i]} + PHALF;
                    corr = 32'(rndp >> NSH);
                    stg_next.pb[i] = stg_prev.d[i][CB]
                        ? sat_coord(32'($signed(stg_prev.pb[i])) - corr)
                        : sat_coord(32'($signed(stg_prev.pb[i])) + corr);
                end
            end

            // Velocity corrections
            if (k == S_KMUL)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    stg_next.pka[i] = PKW'(stg_prev.klow_a) * PKW'(stg_prev.nmag[i]);
                    stg_next.pkb[i] = PKW'(stg_prev.klow_b) * PKW'(stg_prev.nmag[i]);
                end
            end

            if (k == S_VAPP)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rndk = {1'b0, stg_prev.pka[i]} + KHALF;
                    corr = 32'(rndk >> KSH);
                    stg_next.va[i] = stg_prev.d[i][CB]
                        ? sat_coord(32'($signed(stg_prev.va[i])) + corr)
                        : sat_coord(32'($signed(stg_prev.va[i])) - corr);
                    rndk = {1'b0, stg_prev.pkb[i]} + KHALF;
                    corr = 32'(rndk >> KSH);
                    stg_next.vb[i] = stg_prev.d[i][CB]
                        ? sat_coord(32'($signed(stg_prev.vb[i])) - corr)
                        : sat_coord(32'($signed(stg_prev.vb[i])) + corr);
                end
            end
        end

        // Stage payload
        always_ff @(posedge clk)
        begin
            if (rdy[k])
                stg_reg[k] <= stg_next;
        end
    end

    // Output register is the last stage
    assign result.valid       = valid_reg[NS-1];
    assign result.hit         = stg_reg[NS-1].hit;
    assign result.penetration = stg_reg[NS-1].pen;
    assign result.normal      = stg_reg[NS-1].nrm;
    assign result.new_pos_a   = stg_reg[NS-1].pa;
    assign result.new_vel_a   = stg_reg[NS-1].va;
    assign result.new_pos_b   = stg_reg[NS-1].pb;
    assign result.new_vel_b   = stg_reg[NS-1].vb;

    // A miss reports no depth and no normal
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |-> result.penetration == '0 && result.normal == '0)
        else $error("miss with nonzero penetration or normal");

    // A hit always has positive depth
    a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |-> result.penetration != '0)
        else $error("hit with zero penetration");

    // An accepted pair occupies the first stage
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        bodies.valid && bodies.ready |=> valid_reg[0])
        else $error("accepted pair lost at entry");

    // Normal magnitudes never exceed one in Q1.14
    a_nmag: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_NFIN] |-> stg_reg[S_NFIN].nmag[0] <= NQ'(16384)
                           && stg_reg[S_NFIN].nmag[1] <= NQ'(16384)
                           && stg_reg[S_NFIN].nmag[2] <= NQ'(16384))
        else $error("normal component out of range");

    // Coincident centers give a zero root
    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_HIT] && stg_reg[S_HIT].zero |-> stg_reg[S_HIT].root == '0)
        else $error("nonzero root for zero distance");

endmodule
